// ===== hw/rtl/bpmd_pkg.sv =====
package bpmd_pkg;

    localparam int SUM_BITS      = 24;
    localparam int DRV_BITS      = ((SUM_BITS + 16) > 26 ? (SUM_BITS + 16) : 26) + 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_KP       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KI_DT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KD_DT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RATE = 3'd5;

    localparam logic [2:0] GEAR_DIV1  = 3'd0;
    localparam logic [2:0] GEAR_DIV2  = 3'd1;
    localparam logic [2:0] GEAR_DIV4  = 3'd2;
    localparam logic [2:0] GEAR_DIV8  = 3'd3;
    localparam logic [2:0] GEAR_DIV16 = 3'd4;

    localparam logic [2:0] SEL_DIV1  = 3'd0;
    localparam logic [2:0] SEL_DIV2  = 3'd4;
    localparam logic [2:0] SEL_DIV4  = 3'd2;
    localparam logic [2:0] SEL_DIV8  = 3'd6;
    localparam logic [2:0] SEL_DIV16 = 3'd7;

    localparam logic [DRV_BITS-1:0] THR_1500 = DRV_BITS'(1500 * 256);
    localparam logic [DRV_BITS-1:0] THR_1200 = DRV_BITS'(1200 * 256);
    localparam logic [DRV_BITS-1:0] THR_600  = DRV_BITS'(600 * 256);
    localparam logic [DRV_BITS-1:0] THR_500  = DRV_BITS'(500 * 256);
    localparam logic [DRV_BITS-1:0] THR_350  = DRV_BITS'(350 * 256);
    localparam logic [DRV_BITS-1:0] THR_250  = DRV_BITS'(250 * 256);
    localparam logic [DRV_BITS-1:0] THR_150  = DRV_BITS'(150 * 256);
    localparam logic [DRV_BITS-1:0] THR_50   = DRV_BITS'(50 * 256);

    localparam logic [30:0] FREQ_SAT_LIMIT = 31'd589824;
    localparam logic [40:0] RECIP_NINE     = 41'd1864136;
    localparam int          RECIP_SHIFT    = 24;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki_dt;
        logic signed [15:0] kd_dt;
        logic signed [7:0]  target;
        logic [6:0]         limit;
        logic [9:0]         min_rate;
    } cfg_t;

    typedef struct packed {
        logic signed [8:0] angle_error;
        logic [15:0]       speed;
        logic              reverse;
        logic [2:0]        ms_sel;
        logic [2:0]        ms_log2;
        logic [31:0]       mag32;
        logic              enable;
        logic              fallen;
    } mid_t;

    typedef struct packed {
        logic signed [8:0] angle_error;
        logic [15:0]       speed;
        logic              reverse;
        logic [2:0]        ms_sel;
        logic [2:0]        ms_log2;
        logic [15:0]       freq;
        logic              stepping;
        logic              enable;
        logic              fallen;
    } res_t;

    function automatic logic [2:0] gear_update(input logic [DRV_BITS-1:0] mag,
                                               input logic [2:0] gear);
        logic [2:0] g;
        g = gear;
        if (mag > THR_1500 && g == GEAR_DIV2)  g = GEAR_DIV1;
        if (mag < THR_1200 && g == GEAR_DIV1)  g = GEAR_DIV2;
        if (mag > THR_600  && g == GEAR_DIV4)  g = GEAR_DIV2;
        if (mag < THR_500  && g == GEAR_DIV2)  g = GEAR_DIV4;
        if (mag > THR_350  && g == GEAR_DIV8)  g = GEAR_DIV4;
        if (mag < THR_250  && g == GEAR_DIV4)  g = GEAR_DIV8;
        if (mag > THR_150  && g == GEAR_DIV16) g = GEAR_DIV8;
        if (mag < THR_50   && g == GEAR_DIV8)  g = GEAR_DIV16;
        return g;
    endfunction

    function automatic logic [2:0] select_bits(input logic [2:0] gear);
        logic [2:0] s;
        case (gear)
            GEAR_DIV1: s = SEL_DIV1;
            GEAR_DIV2: s = SEL_DIV2;
            GEAR_DIV4: s = SEL_DIV4;
            GEAR_DIV8: s = SEL_DIV8;
            default:   s = SEL_DIV16;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/bpmd_config.sv =====
module bpmd_config (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [bpmd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bpmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output bpmd_pkg::cfg_t                      cfg
);

    bpmd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp       <= 16'shE700;
            cfg_reg.ki_dt    <= 16'shFD80;
            cfg_reg.kd_dt    <= 16'shFFCD;
            cfg_reg.target   <= 8'sd0;
            cfg_reg.limit    <= 7'd40;
            cfg_reg.min_rate <= 10'd50;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpmd_pkg::REG_KP:       cfg_reg.kp       <= cfg_data;
                bpmd_pkg::REG_KI_DT:    cfg_reg.ki_dt    <= cfg_data;
                bpmd_pkg::REG_KD_DT:    cfg_reg.kd_dt    <= cfg_data;
                bpmd_pkg::REG_TARGET:   cfg_reg.target   <= cfg_data[7:0];
                bpmd_pkg::REG_LIMIT:    cfg_reg.limit    <= cfg_data[6:0];
                bpmd_pkg::REG_MIN_RATE: cfg_reg.min_rate <= cfg_data[9:0];
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bpmd_control.sv =====
module bpmd_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic signed [7:0]   roll,
    input  bpmd_pkg::cfg_t      cfg,
    output bpmd_pkg::mid_t      mid
);

    localparam int SB = bpmd_pkg::SUM_BITS;
    localparam int DB = bpmd_pkg::DRV_BITS;

    logic signed [SB-1:0] sum_reg;
    logic signed [9:0]    last_error_reg;
    logic [2:0]           gear_reg;
    logic                 fallen_reg;
    logic                 enable_reg;
    bpmd_pkg::mid_t       mid_reg;

    logic signed [8:0]    err;
    logic signed [SB:0]   sum_wide;
    logic signed [SB-1:0] sum_sat;
    logic signed [9:0]    diff;
    logic signed [24:0]   p_kp;
    logic signed [SB+15:0] p_ki;
    logic signed [25:0]   p_kd;
    logic signed [DB-1:0] drive;
    logic [DB-1:0]        mag;
    logic signed [8:0]    roll_ext;
    logic signed [8:0]    lim_ext;
    logic                 fall;
    logic                 fallen_any;
    logic                 recover;
    logic                 fallen_next;
    logic                 enable_next;
    logic [2:0]           gear_next;
    logic [15:0]          speed;
    logic [31:0]          mag32;

    always_comb
    begin
        err      = 9'(cfg.target) - 9'(roll);
        sum_wide = (SB+1)'(sum_reg) + (SB+1)'(err);
        if (sum_wide[SB] != sum_wide[SB-1])
        begin
            sum_sat = sum_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SB-1:0];
        end
        diff  = 10'(err) - last_error_reg;
        p_kp  = 25'(cfg.kp) * 25'(err);
        p_ki  = (SB+16)'(cfg.ki_dt) * (SB+16)'(sum_sat);
        p_kd  = 26'(cfg.kd_dt) * 26'(diff);
        drive = DB'(p_kp) + DB'(p_ki) + DB'(p_kd);
        mag   = drive[DB-1] ? DB'(-drive) : DB'(drive);

        roll_ext    = 9'(roll);
        lim_ext     = $signed({2'b00, cfg.limit});
        fall        = (roll_ext > lim_ext) || (roll_ext < -lim_ext);
        fallen_any  = fall || fallen_reg;
        recover     = fallen_any && (roll == 8'sd0);
        fallen_next = fallen_any && !recover;
        if (fall)
        begin
            enable_next = 1'b0;
        end
        else if (recover)
        begin
            enable_next = 1'b1;
        end
        else
        begin
            enable_next = enable_reg;
        end

        gear_next = bpmd_pkg::gear_update(mag, gear_reg);
        speed     = (|mag[DB-1:24]) ? 16'hFFFF : mag[23:8];
        mag32     = (|mag[DB-1:32]) ? 32'hFFFF_FFFF : mag[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            last_error_reg <= '0;
            gear_reg       <= bpmd_pkg::GEAR_DIV16;
            fallen_reg     <= 1'b1;
            enable_reg     <= 1'b1;
        end
        else if (advance)
        begin
            sum_reg        <= fallen_any ? '0 : sum_sat;
            last_error_reg <= (fall || recover) ? 10'sd0 : 10'(err);
            gear_reg       <= gear_next;
            fallen_reg     <= fallen_next;
            enable_reg     <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid_reg.angle_error <= err;
            mid_reg.speed       <= speed;
            mid_reg.reverse     <= drive[DB-1];
            mid_reg.ms_sel      <= bpmd_pkg::select_bits(gear_next);
            mid_reg.ms_log2     <= gear_next;
            mid_reg.mag32       <= mag32;
            mid_reg.enable      <= enable_next;
            mid_reg.fallen      <= fallen_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ===== hw/rtl/bpmd_freq.sv =====
module bpmd_freq (
    input  logic            clk,
    input  logic            advance,
    input  bpmd_pkg::mid_t  mid,
    input  logic [9:0]      min_rate,
    output bpmd_pkg::res_t  res
);

    bpmd_pkg::res_t res_reg;

    logic [35:0] shifted;
    logic [38:0] times5;
    logic [30:0] scaled;
    logic [40:0] prod;
    logic [15:0] freq;
    logic        stepping;

    always_comb
    begin
        shifted  = 36'(mid.mag32) << mid.ms_log2;
        times5   = 39'(shifted) + (39'(shifted) << 2);
        scaled   = times5[38:8];
        prod     = 41'(scaled[19:0]) * bpmd_pkg::RECIP_NINE;
        if (scaled >= bpmd_pkg::FREQ_SAT_LIMIT)
        begin
            freq = 16'hFFFF;
        end
        else
        begin
            freq = prod[bpmd_pkg::RECIP_SHIFT+15:bpmd_pkg::RECIP_SHIFT];
        end
        stepping = (freq != 16'd0) && (freq >= 16'(min_rate));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.angle_error <= mid.angle_error;
            res_reg.speed       <= mid.speed;
            res_reg.reverse     <= mid.reverse;
            res_reg.ms_sel      <= mid.ms_sel;
            res_reg.ms_log2     <= mid.ms_log2;
            res_reg.freq        <= freq;
            res_reg.stepping    <= stepping;
            res_reg.enable      <= mid.enable;
            res_reg.fallen      <= mid.fallen;
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/balance_pid_microstep_drive_top.sv =====
// Balance PID drive: each input transfer is one control tick carrying a signed roll angle,
// and each tick yields one result transfer with the angle error, the saturated drive
// magnitude and direction, the microstep gear and select bits, the step frequency and the
// driver status. One tick is accepted every cycle while the output side keeps up; each tick
// passes the roll, control and result registers. The rate is set by the state loop through
// the three PID multiplies, the error sum and the gear hysteresis, which close in the control
// stage; the step frequency is formed in a second stage. Configuration writes take effect at
// once and are meant to be made while no tick is in flight.
module balance_pid_microstep_drive_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [7:0]                   roll_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [8:0]                   angle_error,
    output logic [15:0]                         speed_magnitude,
    output logic                                reverse_dir,
    output logic [2:0]                          microstep_select,
    output logic [2:0]                          microstep_log2,
    output logic [15:0]                         step_freq,
    output logic                                stepping,
    output logic                                driver_enable,
    output logic                                fallen_flag,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpmd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bpmd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic              s0_valid_reg;
    logic signed [7:0] roll_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    bpmd_pkg::cfg_t    cfg;
    bpmd_pkg::mid_t    mid;
    bpmd_pkg::res_t    res;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance || !s0_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (advance)
            begin
                s1_valid_reg  <= s0_valid_reg;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            roll_reg <= roll_angle;
        end
    end

    bpmd_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpmd_control u_control (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance && s0_valid_reg),
        .roll    (roll_reg),
        .cfg     (cfg),
        .mid     (mid)
    );

    bpmd_freq u_freq (
        .clk      (clk),
        .advance  (advance && s1_valid_reg),
        .mid      (mid),
        .min_rate (cfg.min_rate),
        .res      (res)
    );

    assign out_valid        = out_valid_reg;
    assign angle_error      = res.angle_error;
    assign speed_magnitude  = res.speed;
    assign reverse_dir      = res.reverse;
    assign microstep_select = res.ms_sel;
    assign microstep_log2   = res.ms_log2;
    assign step_freq        = res.freq;
    assign stepping         = res.stepping;
    assign driver_enable    = res.enable;
    assign fallen_flag      = res.fallen;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> microstep_log2 <= bpmd_pkg::GEAR_DIV16)
        else $error("microstep gear out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fallen_flag) |-> driver_enable)
        else $error("driver disabled while robot upright");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stepping) |-> (step_freq != 16'd0))
        else $error("stepping at zero frequency");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((microstep_log2 == bpmd_pkg::GEAR_DIV16)
                       == (microstep_select == bpmd_pkg::SEL_DIV16)))
        else $error("select bits disagree with gear");
`endif

endmodule

// ===== verif/balance_pid_microstep_drive_top_test.sv =====
module balance_pid_microstep_drive_top_test;

    localparam longint SUM_MAX       = (longint'(1) << (bpmd_pkg::SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN       = -SUM_MAX - 1;
    localparam longint MAG_CAP       = 64'h0000_0000_FFFF_FFFF;
    localparam longint Q8            = 256;
    localparam int     STEADY_TICKS  = 64;
    localparam int     RANDOM_PHASES = 5;
    localparam int     PHASE_TICKS   = 200;
    localparam int     HOLD_AT       = 300;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     CYCLE_LIMIT   = 2000000;

    class drive_scoreboard;
        logic signed [15:0] kp_q8;
        logic signed [15:0] ki_dt_q8;
        logic signed [15:0] kd_dt_q8;
        logic signed [7:0]  target;
        logic [6:0]         limit;
        logic [9:0]         min_rate;
        longint             err_sum;
        longint             prev_err;
        logic [2:0]         gear;
        bit                 fallen;
        bit                 enabled;
        bpmd_pkg::res_t     expected_q[$];
        int                 mismatches;
        int                 ticks;
        int                 checked;
        int                 writes;
        int                 falls;
        int                 recoveries;
        int                 saturations;
        int                 stepping_ticks;
        logic [4:0]         gears_seen;

        function new();
            kp_q8      = -16'sd6400;
            ki_dt_q8   = -16'sd640;
            kd_dt_q8   = -16'sd51;
            target     = 8'sd0;
            limit      = 7'd40;
            min_rate   = 10'd50;
            err_sum    = 0;
            prev_err   = 0;
            gear       = bpmd_pkg::GEAR_DIV16;
            fallen     = 1'b1;
            enabled    = 1'b1;
            gears_seen = '0;
        endfunction

        function void write_reg(logic [bpmd_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [bpmd_pkg::CFG_DATA_BITS-1:0] d);
            case (idx)
                bpmd_pkg::REG_KP:       kp_q8 = d;
                bpmd_pkg::REG_KI_DT:    ki_dt_q8 = d;
                bpmd_pkg::REG_KD_DT:    kd_dt_q8 = d;
                bpmd_pkg::REG_TARGET:   target = d[7:0];
                bpmd_pkg::REG_LIMIT:    limit = d[6:0];
                bpmd_pkg::REG_MIN_RATE: min_rate = d[9:0];
                default:      ;
            endcase
            writes++;
        endfunction

        function void step_gear(longint mag);
            if (mag > 1500 * Q8 && gear == bpmd_pkg::GEAR_DIV2)  gear = bpmd_pkg::GEAR_DIV1;
            if (mag < 1200 * Q8 && gear == bpmd_pkg::GEAR_DIV1)  gear = bpmd_pkg::GEAR_DIV2;
            if (mag > 600 * Q8  && gear == bpmd_pkg::GEAR_DIV4)  gear = bpmd_pkg::GEAR_DIV2;
            if (mag < 500 * Q8  && gear == bpmd_pkg::GEAR_DIV2)  gear = bpmd_pkg::GEAR_DIV4;
            if (mag > 350 * Q8  && gear == bpmd_pkg::GEAR_DIV8)  gear = bpmd_pkg::GEAR_DIV4;
            if (mag < 250 * Q8  && gear == bpmd_pkg::GEAR_DIV4)  gear = bpmd_pkg::GEAR_DIV8;
            if (mag > 150 * Q8  && gear == bpmd_pkg::GEAR_DIV16) gear = bpmd_pkg::GEAR_DIV8;
            if (mag < 50 * Q8   && gear == bpmd_pkg::GEAR_DIV8)  gear = bpmd_pkg::GEAR_DIV16;
        endfunction

        function void note_tick(logic signed [7:0] roll);
            longint r;
            longint lim;
            longint e;
            longint kp;
            longint ki;
            longint kd;
            longint drive;
            longint mag;
            longint m32;
            longint f;
            bpmd_pkg::res_t want;
            r  = roll;
            lim = limit;
            e  = target;
            e  = e - r;
            kp = kp_q8;
            ki = ki_dt_q8;
            kd = kd_dt_q8;
            if (e > 0 && err_sum > SUM_MAX - e) begin
                err_sum = SUM_MAX;
                saturations++;
            end else if (e < 0 && err_sum < SUM_MIN - e) begin
                err_sum = SUM_MIN;
                saturations++;
            end else begin
                err_sum = err_sum + e;
            end
            drive = kp * e + ki * err_sum + kd * (e - prev_err);
            prev_err = e;
            want.reverse = drive < 0;
            mag = (drive < 0) ? -drive : drive;

            if (r > lim || r < -lim) begin
                if (!fallen)
                    falls++;
                fallen   = 1'b1;
                enabled  = 1'b0;
                err_sum  = 0;
                prev_err = 0;
            end
            if (fallen) begin
                err_sum = 0;
                if (r == 0) begin
                    fallen   = 1'b0;
                    enabled  = 1'b1;
                    prev_err = 0;
                    recoveries++;
                end
            end

            step_gear(mag);
            gears_seen[gear] = 1'b1;

            f = mag >> 8;
            if (f > 65535)
                f = 65535;
            want.speed = f[15:0];
            m32 = (mag > MAG_CAP) ? MAG_CAP : mag;
            f = ((m32 << gear) * 5) / 2304;
            if (f > 65535)
                f = 65535;
            want.freq     = f[15:0];
            want.stepping = (f != 0) && (f >= longint'(min_rate));
            if (want.stepping)
                stepping_ticks++;
            want.angle_error = e[8:0];
            want.ms_log2     = gear;
            case (gear)
                bpmd_pkg::GEAR_DIV1: want.ms_sel = bpmd_pkg::SEL_DIV1;
                bpmd_pkg::GEAR_DIV2: want.ms_sel = bpmd_pkg::SEL_DIV2;
                bpmd_pkg::GEAR_DIV4: want.ms_sel = bpmd_pkg::SEL_DIV4;
                bpmd_pkg::GEAR_DIV8: want.ms_sel = bpmd_pkg::SEL_DIV8;
                default:             want.ms_sel = bpmd_pkg::SEL_DIV16;
            endcase
            want.enable = enabled;
            want.fallen = fallen;
            expected_q.push_back(want);
            ticks++;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            if (mismatches < 20)
                $display("Mismatch at result %0d, %s: got %0d, expected %0d",
                         checked, what, got, want);
            mismatches++;
        endtask

        task check_result(bpmd_pkg::res_t got);
            bpmd_pkg::res_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no pending tick", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.angle_error !== want.angle_error)
                    report_mismatch("angle_error", got.angle_error, want.angle_error);
                if (got.speed !== want.speed)
                    report_mismatch("speed_magnitude", got.speed, want.speed);
                if (got.reverse !== want.reverse)
                    report_mismatch("reverse_dir", got.reverse, want.reverse);
                if (got.ms_sel !== want.ms_sel)
                    report_mismatch("microstep_select", got.ms_sel, want.ms_sel);
                if (got.ms_log2 !== want.ms_log2)
                    report_mismatch("microstep_log2", got.ms_log2, want.ms_log2);
                if (got.freq !== want.freq)
                    report_mismatch("step_freq", got.freq, want.freq);
                if (got.stepping !== want.stepping)
                    report_mismatch("stepping", got.stepping, want.stepping);
                if (got.enable !== want.enable)
                    report_mismatch("driver_enable", got.enable, want.enable);
                if (got.fallen !== want.fallen)
                    report_mismatch("fallen_flag", got.fallen, want.fallen);
            end
            checked++;
        endtask
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [7:0]                   roll_angle;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [8:0]                   angle_error;
    logic [15:0]                         speed_magnitude;
    logic                                reverse_dir;
    logic [2:0]                          microstep_select;
    logic [2:0]                          microstep_log2;
    logic [15:0]                         step_freq;
    logic                                stepping;
    logic                                driver_enable;
    logic                                fallen_flag;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [bpmd_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [bpmd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    drive_scoreboard sb = new();
    int  cycles;
    int  ticks_sent;
    int  burst_left;
    int  walk;
    bit  steady;
    logic hold_req;
    logic hold_done;
    int  hold_left;
    int  rx_mode;
    int  rx_left;
    logic [1:0] rx_phase;

    balance_pid_microstep_drive_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .roll_angle       (roll_angle),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .angle_error      (angle_error),
        .speed_magnitude  (speed_magnitude),
        .reverse_dir      (reverse_dir),
        .microstep_select (microstep_select),
        .microstep_log2   (microstep_log2),
        .step_freq        (step_freq),
        .stepping         (stepping),
        .driver_enable    (driver_enable),
        .fallen_flag      (fallen_flag),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, sb.expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : rx_pattern
        logic ready_bit;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   <= 0;
            rx_left   <= 0;
            rx_phase  <= '0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(16, 128);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 2'd1;
            case (rx_mode)
                0:       ready_bit = 1'b1;
                1:       ready_bit = (rx_phase != 2'd3);
                2:       ready_bit = 1'($urandom_range(0, 1));
                default: ready_bit = ($urandom_range(0, 3) == 0);
            endcase
            out_ready <= ready_bit && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        bpmd_pkg::res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.angle_error = angle_error;
            got.speed       = speed_magnitude;
            got.reverse     = reverse_dir;
            got.ms_sel      = microstep_select;
            got.ms_log2     = microstep_log2;
            got.freq        = step_freq;
            got.stepping    = stepping;
            got.enable      = driver_enable;
            got.fallen      = fallen_flag;
            sb.check_result(got);
        end
    end

    task automatic push_tick(input logic signed [7:0] r);
        in_valid   <= 1'b1;
        roll_angle <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(r);
        ticks_sent++;
        if (ticks_sent == HOLD_AT)
            hold_req <= 1'b1;
        if (steady)
        begin
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic cfg_write(input logic [bpmd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [bpmd_pkg::CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic configure(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] tgt,
                             input logic [15:0] lim, input logic [15:0] rate);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write(bpmd_pkg::REG_KP, kp);
        cfg_write(bpmd_pkg::REG_KI_DT, ki);
        cfg_write(bpmd_pkg::REG_KD_DT, kd);
        cfg_write(bpmd_pkg::REG_TARGET, tgt);
        cfg_write(bpmd_pkg::REG_LIMIT, lim);
        cfg_write(bpmd_pkg::REG_MIN_RATE, rate);
        cfg_valid <= 1'b0;
        walk = 0;
    endtask

    function automatic logic [15:0] pick_gain();
        logic [15:0] g;
        case ($urandom_range(0, 3))
            0:       g = 16'($urandom);
            3:       g = 16'($urandom_range(0, 2000));
            default: g = 16'(0 - $urandom_range(0, 8000));
        endcase
        return g;
    endfunction

    function automatic logic signed [7:0] next_roll();
        int v;
        int lim;
        int pick;
        int span;
        lim  = sb.limit;
        pick = $urandom_range(0, 99);
        if (sb.fallen)
        begin
            walk = 0;
            if (pick < 30)
            begin
                v = 0;
            end
            else
            begin
                v = $urandom_range(0, 255);
                v = v - 128;
            end
        end
        else if (pick < 4)
        begin
            if (lim == 127 || $urandom_range(0, 1) == 0)
            begin
                span = $urandom_range(0, 127 - lim);
                v = -(lim + 1 + span);
            end
            else
            begin
                span = $urandom_range(0, 126 - lim);
                v = lim + 1 + span;
            end
        end
        else if (pick < 10)
        begin
            v = $urandom_range(0, 255);
            v = v - 128;
        end
        else if (pick < 16)
        begin
            v = ($urandom_range(0, 1) == 0) ? lim : -lim;
        end
        else
        begin
            span = $urandom_range(0, 12);
            walk = walk + span - 6;
            if (walk > lim)
                walk = lim;
            if (walk < -lim)
                walk = -lim;
            v = walk;
        end
        return v[7:0];
    endfunction

    initial
    begin : stimulus
        logic signed [7:0] tgt;
        logic [6:0]        lim;
        logic [9:0]        rate;
        int                t;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        roll_angle = '0;
        cfg_valid  = 1'b0;
        cfg_index  = bpmd_pkg::REG_KP;
        cfg_data   = '0;
        hold_req   = 1'b0;
        steady     = 1'b0;
        burst_left = 0;
        walk       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: recovery from the fallen reset state, the tilt boundary,
        // falls on either side, the hold while fallen and a gear climb.
        push_tick(8'sd0);
        push_tick(8'sd20);
        push_tick(8'sd40);
        push_tick(8'sd41);
        push_tick(8'sd5);
        push_tick(8'sd0);
        push_tick(-8'sd40);
        push_tick(-8'sd41);
        push_tick(8'sd0);
        push_tick(8'sd127);
        push_tick(-8'sd128);
        push_tick(8'sd0);
        push_tick(-8'sd1);
        push_tick(8'sd35);
        push_tick(8'sd35);
        push_tick(8'sd35);

        configure(16'h8000, 16'h7FFF, 16'h8000, 16'h0080, 16'h0000, 16'h0000);
        push_tick(8'sd0);
        push_tick(-8'sd128);
        push_tick(8'sd127);
        push_tick(8'sd0);
        push_tick(8'sd1);

        configure(16'h7FFF, 16'h8000, 16'h7FFF, 16'h007F, 16'h007F, 16'h03FF);
        push_tick(8'sd0);
        push_tick(-8'sd128);
        push_tick(8'sd127);
        push_tick(-8'sd127);
        push_tick(8'sd0);

        // Zero gains give a zero step rate, which must not step even at a zero minimum.
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h007F, 16'h0000);
        push_tick(8'sd0);
        push_tick(8'sd0);
        push_tick(8'sd3);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            t = $urandom_range(0, 9);
            if (t < 7)
            begin
                t = $urandom_range(0, 20);
                t = t - 10;
            end
            else
            begin
                t = $urandom_range(0, 255);
            end
            tgt  = t[7:0];
            lim  = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(20, 90));
            rate = 10'($urandom_range(0, 1023));
            configure(pick_gain(), pick_gain(), pick_gain(),
                      {8'($urandom), tgt}, {9'($urandom), lim}, {6'($urandom), rate});
            repeat (PHASE_TICKS) push_tick(next_roll());
        end

        // Back-to-back run with an error of 254, so the sum and the drive grow each tick.
        steady = 1'b1;
        configure(-16'sd256, -16'sd1, 16'h0000, 16'h007F, 16'h007F, 16'd50);
        push_tick(8'sd0);
        repeat (STEADY_TICKS) push_tick(-8'sd127);
        push_tick(-8'sd128);
        push_tick(8'sd0);
        steady = 1'b0;

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("ticks left without result", sb.expected_q.size(), 0);

        $display("Checked %0d results over %0d ticks and %0d register writes.",
                 sb.checked, sb.ticks, sb.writes);
        $display("Falls %0d, recoveries %0d, saturated sums %0d, stepping %0d, gears %05b.",
                 sb.falls, sb.recoveries, sb.saturations, sb.stepping_ticks, sb.gears_seen);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
